FILE: rtl/core/hsfc_pkg.sv
// hsfc_pkg: shared types, constants and the crc-16 byte update for the
// humidity sensor frame checker; no dependencies
`default_nettype none

package hsfc_pkg;

  // crc-16 (modbus) constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // temperature word layout (sign-magnitude)
  localparam int unsigned SIGN_POS = 15;
  localparam logic [14:0] MAG_MASK = 15'h7FFF;

  // configuration register reset values
  localparam logic [7:0] FUNC_CODE_RST = 8'h03;
  localparam logic [7:0] REG_COUNT_RST = 8'h04;

  // configuration register indexes
  typedef enum logic {
    REG_FUNC_CODE = 1'b0,
    REG_REG_COUNT = 1'b1
  } cfg_reg_t;

  // frame status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_BAD_CRC    = 2'd2
  } status_t;

  // byte position in the 8-byte reply
  typedef enum logic [2:0] {
    POS_FUNC_CODE = 3'd0,
    POS_REG_COUNT = 3'd1,
    POS_HUM_HI    = 3'd2,
    POS_HUM_LO    = 3'd3,
    POS_TEMP_HI   = 3'd4,
    POS_TEMP_LO   = 3'd5,
    POS_CRC_LO    = 3'd6,
    POS_CRC_HI    = 3'd7
  } pos_t;

  // one result item
  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [15:0]        humidity_tenths;
    status_t            frame_status;
  } result_t;

  // status from the frame tracker to the top level
  typedef struct packed {
    logic    advance;
    logic    res_valid;
    result_t res;
  } frame_stat_t;

  // one reflected crc-16 byte update, eight bit steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/humidity_sensor_frame_checker.sv
// a byte is held in the input register; the result of a frame shows on
// out_tvalid from the result register once its last byte leaves the input register
// throughput: one byte per cycle; the only stall is the result register
// when a frame ends while the previous result has not been taken
// reset: rst_n synchronous active low; clears valids, frame state and
// restores both header registers to their reset values
`default_nettype none

module humidity_sensor_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [7:0]  cfg_wdata,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] reply_byte
  input  wire logic        in_tuser,   // [0] frame_start
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // [1:0] frame_status, [17:2] humidity_tenths,
                                       // [33:18] temperature_tenths, [39:34] zero
);

  logic [7:0]            func_code_r;
  logic [7:0]            reg_count_r;
  logic                  s1_valid_r, s1_valid_nxt;
  logic [7:0]            s1_byte_r;
  logic                  s1_start_r;
  logic                  out_valid_r, out_valid_nxt;
  hsfc_pkg::result_t     out_res_r;
  logic                  slot_free;
  logic                  in_acc;
  hsfc_pkg::frame_stat_t fstat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_code_r <= hsfc_pkg::FUNC_CODE_RST;
      reg_count_r <= hsfc_pkg::REG_COUNT_RST;
    end else if (cfg_we) begin
      case (hsfc_pkg::cfg_reg_t'(cfg_addr))
        hsfc_pkg::REG_FUNC_CODE: func_code_r <= cfg_wdata;
        hsfc_pkg::REG_REG_COUNT: reg_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || fstat.advance;
  assign in_acc    = in_tvalid && in_tready;

  // input register
  assign s1_valid_nxt = in_acc ? 1'b1 : (fstat.advance ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  // frame tracking and decode
  hsfc_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (s1_valid_r),
    .in_byte       (s1_byte_r),
    .in_start      (s1_start_r),
    .slot_free     (slot_free),
    .exp_func_code (func_code_r),
    .exp_reg_count (reg_count_r),
    .stat          (fstat)
  );

  // result register
  assign out_valid_nxt = fstat.res_valid ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fstat.res_valid) begin
      out_res_r <= fstat.res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_res_r};

endmodule

`default_nettype wire

FILE: rtl/core/hsfc_frame.sv
// hsfc_frame: per-frame state (position, crc, header check, data words)
// and the result decode; depends on hsfc_pkg
`default_nettype none

module hsfc_frame (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [7:0]          in_byte,
  input  wire logic                in_start,
  input  wire logic                slot_free,
  input  wire logic [7:0]          exp_func_code,
  input  wire logic [7:0]          exp_reg_count,
  output hsfc_pkg::frame_stat_t    stat
);

  hsfc_pkg::pos_t pos_r, pos_nxt, pos_eff;
  logic [15:0]    crc_r, crc_nxt, crc_eff;
  logic           hdr_r, hdr_nxt, hdr_eff;
  logic [15:0]    hum_r, hum_nxt;
  logic [15:0]    temp_r, temp_nxt;
  logic [7:0]     crc_lo_r, crc_lo_nxt;
  logic           last_byte;
  logic           advance;
  logic [15:0]    rx_crc;
  logic [14:0]    mag;
  logic [15:0]    temp_dec;

  // a start mark restarts the frame before this byte is used
  always_comb begin
    pos_eff = in_start ? hsfc_pkg::POS_FUNC_CODE : pos_r;
    crc_eff = in_start ? hsfc_pkg::CRC_INIT : crc_r;
    hdr_eff = in_start ? 1'b1 : hdr_r;
  end

  // the last byte can only move on when the result register is free
  assign last_byte = (pos_eff == hsfc_pkg::POS_CRC_HI);
  assign advance   = in_valid && (!last_byte || slot_free);

  // result decode
  assign rx_crc   = {in_byte, crc_lo_r};
  assign mag      = temp_r[14:0] & hsfc_pkg::MAG_MASK;
  assign temp_dec = temp_r[hsfc_pkg::SIGN_POS] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};

  always_comb begin
    stat.advance   = advance;
    stat.res_valid = advance && last_byte;
    stat.res       = '0;
    if (!hdr_eff) begin
      stat.res.frame_status = hsfc_pkg::ST_BAD_HEADER;
    end else if (rx_crc != crc_eff) begin
      stat.res.frame_status = hsfc_pkg::ST_BAD_CRC;
    end else begin
      stat.res.frame_status       = hsfc_pkg::ST_OK;
      stat.res.humidity_tenths    = hum_r;
      stat.res.temperature_tenths = signed'(temp_dec);
    end
  end

  // next frame state
  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    hdr_nxt    = hdr_r;
    hum_nxt    = hum_r;
    temp_nxt   = temp_r;
    crc_lo_nxt = crc_lo_r;
    if (advance) begin
      pos_nxt = hsfc_pkg::pos_t'(pos_eff + 3'd1);
      crc_nxt = (pos_eff == hsfc_pkg::POS_CRC_LO) ? crc_eff
                                                  : hsfc_pkg::crc_byte(crc_eff, in_byte);
      hdr_nxt = hdr_eff;
      case (pos_eff)
        hsfc_pkg::POS_FUNC_CODE: begin
          if (in_byte != exp_func_code) hdr_nxt = 1'b0;
        end
        hsfc_pkg::POS_REG_COUNT: begin
          if (in_byte != exp_reg_count) hdr_nxt = 1'b0;
        end
        hsfc_pkg::POS_HUM_HI:  hum_nxt[15:8]  = in_byte;
        hsfc_pkg::POS_HUM_LO:  hum_nxt[7:0]   = in_byte;
        hsfc_pkg::POS_TEMP_HI: temp_nxt[15:8] = in_byte;
        hsfc_pkg::POS_TEMP_LO: temp_nxt[7:0]  = in_byte;
        hsfc_pkg::POS_CRC_LO:  crc_lo_nxt     = in_byte;
        hsfc_pkg::POS_CRC_HI: begin
          pos_nxt = hsfc_pkg::POS_FUNC_CODE;
          crc_nxt = hsfc_pkg::CRC_INIT;
          hdr_nxt = 1'b1;
        end
        default: pos_nxt = hsfc_pkg::POS_FUNC_CODE;
      endcase
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= hsfc_pkg::POS_FUNC_CODE;
      crc_r    <= hsfc_pkg::CRC_INIT;
      hdr_r    <= 1'b1;
      hum_r    <= '0;
      temp_r   <= '0;
      crc_lo_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      hdr_r    <= hdr_nxt;
      hum_r    <= hum_nxt;
      temp_r   <= temp_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hsfc_checker.sv
// hsfc_checker: port-level assertions for humidity_sensor_frame_checker,
// attached by the bind at the end; depends on hsfc_pkg
`default_nettype none

module hsfc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // no result item right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == hsfc_pkg::ST_OK) ||
                   (out_tdata[1:0] == hsfc_pkg::ST_BAD_HEADER) ||
                   (out_tdata[1:0] == hsfc_pkg::ST_BAD_CRC))
    else $error("undefined frame status");

  // error results carry zero readings
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != hsfc_pkg::ST_OK) |-> out_tdata[39:2] == '0)
    else $error("error result with nonzero readings");

  // sign-magnitude decode never yields the most negative value
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33:18] != 16'h8000)
    else $error("temperature out of range");

endmodule

bind humidity_sensor_frame_checker hsfc_checker u_hsfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

FILE: verif/tb.sv
// tb: self-checking bench for humidity_sensor_frame_checker; feeds reply bytes,
// predicts header/crc status and decoded readings, checks every result item
// depends on hsfc_pkg and the humidity_sensor_frame_checker rtl
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 4;

  // kinds of damage a generated reply can carry
  typedef enum logic [2:0] {
    FAULT_NONE,
    FAULT_FUNC,
    FAULT_COUNT,
    FAULT_CRC,
    FAULT_BOTH
  } fault_t;

  // one decoded reading as the block should report it
  typedef struct {
    hsfc_pkg::status_t  status;
    logic [15:0]        hum;
    logic signed [15:0] temp;
  } reading_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_addr;
  logic [7:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] reply_byte
  logic        in_tuser;   // [0] frame_start
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [1:0] frame_status, [17:2] humidity_tenths,
                           // [33:18] temperature_tenths, [39:34] zero

  // frame tracker copy of the block state and header settings
  hsfc_pkg::pos_t track_pos;
  logic [15:0]    track_crc;
  logic           track_hdr_ok;
  logic [15:0]    track_hum;
  logic [15:0]    track_temp;
  logic [7:0]     track_crc_lo;
  logic [7:0]     want_func;
  logic [7:0]     want_count;

  reading_t    pending_readings[$];

  int unsigned items_sent;
  int unsigned readings_checked;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          sender_gaps;
  bit          sink_stalls;
  bit          hold_request;

  humidity_sensor_frame_checker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // reflected crc-16 update, one byte, lsb first
  function automatic logic [15:0] crc16_modbus_update(input logic [15:0] crc,
                                                     input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ hsfc_pkg::CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic restart_tracking();
    track_pos    = hsfc_pkg::POS_FUNC_CODE;
    track_crc    = hsfc_pkg::CRC_INIT;
    track_hdr_ok = 1'b1;
  endtask

  // advance the tracker by one accepted byte, queue a reading on the last byte
  task automatic track_reply_byte(input logic [7:0] b, input logic mark);
    reading_t r;
    if (mark) restart_tracking();
    if (track_pos < hsfc_pkg::POS_CRC_LO) track_crc = crc16_modbus_update(track_crc, b);
    if (track_pos == hsfc_pkg::POS_CRC_HI) begin
      r.status = hsfc_pkg::ST_OK;
      r.hum    = 16'h0000;
      r.temp   = 16'sh0000;
      if (!track_hdr_ok) begin
        r.status = hsfc_pkg::ST_BAD_HEADER;
      end else if ({b, track_crc_lo} != track_crc) begin
        r.status = hsfc_pkg::ST_BAD_CRC;
      end else begin
        r.hum  = track_hum;
        r.temp = {1'b0, track_temp[14:0]};
        if (track_temp[15]) r.temp = -r.temp;
      end
      pending_readings.push_back(r);
      restart_tracking();
    end else begin
      case (track_pos)
        hsfc_pkg::POS_FUNC_CODE: if (b != want_func) track_hdr_ok = 1'b0;
        hsfc_pkg::POS_REG_COUNT: if (b != want_count) track_hdr_ok = 1'b0;
        hsfc_pkg::POS_HUM_HI:    track_hum[15:8] = b;
        hsfc_pkg::POS_HUM_LO:    track_hum[7:0] = b;
        hsfc_pkg::POS_TEMP_HI:   track_temp[15:8] = b;
        hsfc_pkg::POS_TEMP_LO:   track_temp[7:0] = b;
        default:                 track_crc_lo = b;
      endcase
      track_pos = hsfc_pkg::pos_t'(track_pos + 3'd1);
    end
  endtask

  // offer one byte and wait for it to be taken; returns on a falling edge
  task automatic send_byte(input logic [7:0] b, input logic mark);
    int unsigned gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= mark;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_reply_byte(b, mark);
    items_sent++;
    @(negedge clk);
  endtask

  // build an 8-byte reply against the current header settings
  task automatic send_reading(input logic [15:0] hum, input logic [15:0] temp,
                              input fault_t fault, input logic mark);
    logic [7:0]  frame [8];
    logic [15:0] crc;
    frame[0] = want_func;
    frame[1] = want_count;
    if (fault == FAULT_FUNC || fault == FAULT_BOTH)
      frame[0] = want_func ^ 8'($urandom_range(1, 255));
    if (fault == FAULT_COUNT)
      frame[1] = want_count ^ 8'($urandom_range(1, 255));
    frame[2] = hum[15:8];
    frame[3] = hum[7:0];
    frame[4] = temp[15:8];
    frame[5] = temp[7:0];
    crc = hsfc_pkg::CRC_INIT;
    for (int i = 0; i < 6; i++) crc = crc16_modbus_update(crc, frame[i]);
    if (fault == FAULT_CRC || fault == FAULT_BOTH)
      crc = crc ^ 16'($urandom_range(1, 65535));
    frame[6] = crc[7:0];
    frame[7] = crc[15:8];
    for (int i = 0; i < 8; i++) send_byte(frame[i], (i == 0) && mark);
  endtask

  // stop offering and wait until every queued reading has come out
  task automatic drain_readings();
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // write both header registers back to back
  task automatic set_header(input logic [7:0] func, input logic [7:0] count);
    cfg_we    <= 1'b1;
    cfg_addr  <= hsfc_pkg::REG_FUNC_CODE;
    cfg_wdata <= func;
    @(negedge clk);
    cfg_addr  <= hsfc_pkg::REG_REG_COUNT;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_we    <= 1'b0;
    want_func  = func;
    want_count = count;
  endtask

  // mostly well-formed replies, some damaged, some stray bytes
  task automatic send_random_traffic(input int unsigned n_bytes);
    int unsigned first, r, len;
    fault_t      fault;
    logic [15:0] hum, temp;
    logic        mark;
    first = items_sent;
    while (items_sent - first < n_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        len = $urandom_range(1, 7);
        repeat (len) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) fault = FAULT_NONE;
        else if (r < 78) fault = FAULT_FUNC;
        else if (r < 86) fault = FAULT_COUNT;
        else if (r < 94) fault = FAULT_CRC;
        else fault = FAULT_BOTH;
        case ($urandom_range(0, 9))
          0: temp = 16'h8000;
          1: temp = 16'h7FFF;
          2: temp = 16'hFFFF;
          3: temp = 16'h0000;
          default: temp = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
          0: hum = 16'h0000;
          1: hum = 16'hFFFF;
          default: hum = 16'($urandom);
        endcase
        // a reply that starts off a frame boundary must carry the start mark
        mark = (track_pos != hsfc_pkg::POS_FUNC_CODE) || ($urandom_range(0, 1) == 1);
        send_reading(hum, temp, fault, mark);
      end
    end
  endtask

  // extremes, wrap without start mark, negative zero, resync, both errors
  task automatic test_directed_frames();
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    send_reading(16'hFFFF, 16'hFFFF, FAULT_NONE, 1'b1);
    send_reading(16'h0000, 16'h8000, FAULT_NONE, 1'b0);
    send_byte(want_func, 1'b1);
    send_byte(want_count, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_reading(16'h0190, 16'h00F5, FAULT_BOTH, 1'b1);
    drain_readings();
  endtask

  // random traffic under several header settings, extremes included
  task automatic test_header_settings();
    logic [7:0] f, c;
    for (int s = 0; s < 5; s++) begin
      case (s)
        0: begin f = 8'h00; c = 8'hFF; end
        1: begin f = 8'hFF; c = 8'h00; end
        2: begin f = hsfc_pkg::FUNC_CODE_RST; c = hsfc_pkg::REG_COUNT_RST; end
        default: begin f = 8'($urandom); c = 8'($urandom); end
      endcase
      drain_readings();
      set_header(f, c);
      for (int k = 0; k < 4; k++) begin
        sender_gaps = (k != 0) && ($urandom_range(0, 3) != 0);
        sink_stalls = (k != 0) && ($urandom_range(0, 3) != 0);
        send_random_traffic(50);
      end
    end
    drain_readings();
  endtask

  // long receiver hold-off with the sender pushing, then random receiver stalls
  task automatic test_backpressure();
    sender_gaps  = 1'b0;
    sink_stalls  = 1'b0;
    hold_request = 1'b1;
    repeat (6) send_reading(16'($urandom), 16'($urandom), FAULT_NONE, 1'b1);
    drain_readings();
    sink_stalls = 1'b1;
    repeat (3) send_reading(16'($urandom), 16'($urandom), FAULT_NONE, 1'b0);
    drain_readings();
  endtask

  // result receiver: ready, with random stalls when enabled, or a long hold when asked
  initial begin : result_sink
    int unsigned n;
    out_tready = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = pick_gap() + 1;
        repeat (n) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // compare each result item with the oldest queued reading
  always @(posedge clk) begin : reading_check
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result item %h with none expected, got %h", $time,
                 40'h0, out_tdata);
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        check_field("frame_status", 16'(want.status), 16'(out_tdata[1:0]));
        check_field("humidity_tenths", want.hum, out_tdata[17:2]);
        check_field("temperature_tenths", want.temp, out_tdata[33:18]);
        check_field("padding", 16'h0000, 16'(out_tdata[39:34]));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : main
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = hsfc_pkg::REG_FUNC_CODE;
    cfg_wdata    = 8'h00;
    in_tvalid    = 1'b0;
    in_tdata     = 8'h00;
    in_tuser     = 1'b0;
    sender_gaps  = 1'b0;
    sink_stalls  = 1'b0;
    hold_request = 1'b0;
    want_func    = hsfc_pkg::FUNC_CODE_RST;
    want_count   = hsfc_pkg::REG_COUNT_RST;
    track_hum    = 16'h0000;
    track_temp   = 16'h0000;
    track_crc_lo = 8'h00;
    restart_tracking();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_directed_frames();
    test_header_settings();
    test_backpressure();
    drain_readings();

    $display("run covered %0d reply bytes and %0d readings: extremes, resync, wrap,",
             items_sent, readings_checked);
    $display("header and crc faults under five header settings, and back-pressure");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/hsfc_pkg.sv
rtl/core/hsfc_frame.sv
rtl/core/humidity_sensor_frame_checker.sv
rtl/core/hsfc_checker.sv
verif/tb.sv
